[hdl/announce_neighbor_table_assert.svh]
// Assertion macros shared by the neighbour table RTL.
`ifndef ANNOUNCE_NEIGHBOR_TABLE_ASSERT_SVH
`define ANNOUNCE_NEIGHBOR_TABLE_ASSERT_SVH
// Checks a property on the rising clock edge, held off while reset is applied.
`define ANT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks an implication on the rising clock edge, held off while reset is applied.
`define ANT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`endif

[hdl/ant_pkg.sv]
// Types and codes of the announce neighbour table.
package ant_pkg;
  localparam logic [1:0] KIND_ANNOUNCE = 2'd0;
  localparam logic [1:0] KIND_SAVE     = 2'd1;
  localparam logic [1:0] KIND_UNSAVE   = 2'd2;

  localparam logic [3:0] ST_INSERTED  = 4'd0;
  localparam logic [3:0] ST_UPDATED   = 4'd1;
  localparam logic [3:0] ST_OWN       = 4'd2;
  localparam logic [3:0] ST_RATE      = 4'd3;
  localparam logic [3:0] ST_INTERVAL  = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_SAVED     = 4'd6;
  localparam logic [3:0] ST_UNSAVED   = 4'd7;
  localparam logic [3:0] ST_NOT_FOUND = 4'd8;

  localparam logic [2:0] REG_LOCAL_HIGH  = 3'd0;
  localparam logic [2:0] REG_LOCAL_LOW   = 3'd1;
  localparam logic [2:0] REG_LOCAL_VALID = 3'd2;
  localparam logic [2:0] REG_RATE        = 3'd3;
  localparam logic [2:0] REG_MIN_INT     = 3'd4;
  localparam logic [2:0] REG_STALE       = 3'd5;

  localparam logic [31:0] WINDOW_MS = 32'd1000;
  localparam logic [8:0]  WINDOW_COUNT_MAX = 9'd511;

  typedef struct packed {
    logic [63:0]       dest_high;
    logic [63:0]       dest_low;
    logic [63:0]       ident_high;
    logic [63:0]       ident_low;
    logic [31:0]       last_seen;
    logic [7:0]        hops;
    logic signed [9:0] rssi;
    logic signed [9:0] snr;
    logic              saved;
  } entry_t;
endpackage

[hdl/ant_if.sv]
// Valid/ready channel interfaces for items and results.
interface ant_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [63:0]       dest_high;
  logic [63:0]       dest_low;
  logic [63:0]       ident_high;
  logic [63:0]       ident_low;
  logic [31:0]       now_ms;
  logic [7:0]        hop_count;
  logic signed [9:0] rssi_dbm;
  logic signed [9:0] snr_quarter_db;
  modport source (output valid, kind, dest_high, dest_low, ident_high, ident_low, now_ms,
                  hop_count, rssi_dbm, snr_quarter_db, input ready);
  modport sink (input valid, kind, dest_high, dest_low, ident_high, ident_low, now_ms,
                hop_count, rssi_dbm, snr_quarter_db, output ready);
endinterface

interface ant_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [4:0] slot;
  logic [5:0] entry_count;
  modport source (output valid, status, slot, entry_count, input ready);
  modport sink (input valid, status, slot, entry_count, output ready);
endinterface

[hdl/ant_mem.sv]
// Simple dual-port entry memory with a registered read.
module ant_mem #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  ant_pkg::entry_t            wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output ant_pkg::entry_t            rdata
);
  import ant_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/announce_neighbor_table.sv]
// Announce neighbour table: a sequencer around one entry memory of TABLE_DEPTH destinations.
// One item is worked at a time. Own, rate-limited and unused-kind items go straight to the
// result without a search. Every other item searches the entry memory one entry a cycle.
// An announce for a new destination into a full table adds a compaction pass over all entries
// and, if nothing was stale, a worst-entry pass; if that finds an unsaved entry, the last
// entry is read and written into its slot. The single read port of the entry memory sets the
// pace of every pass. The next transaction is taken as soon as the sequencer is idle, even
// while the previous result still waits at the output.
// Entries that were never written are never read, so the memory needs no clearing after reset.
module announce_neighbor_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ant_in_if.sink      in_ch,
  ant_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ant_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_FOUND = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_WRST  = 4'd4;
  localparam logic [3:0] S_MVRD  = 4'd5;
  localparam logic [3:0] S_MVWR  = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Configuration registers.
  logic [63:0] lh_high_r, lh_low_r;
  logic        lh_valid_r;
  logic [7:0]  aps_r;
  logic [31:0] min_int_r, stale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lh_high_r  <= '0;
      lh_low_r   <= '0;
      lh_valid_r <= 1'b0;
      aps_r      <= 8'd20;
      min_int_r  <= 32'd1000;
      stale_r    <= 32'd600000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL_HIGH:  lh_high_r  <= cfg_data;
        REG_LOCAL_LOW:   lh_low_r   <= cfg_data;
        REG_LOCAL_VALID: lh_valid_r <= cfg_data[0];
        REG_RATE:        aps_r      <= cfg_data[7:0];
        REG_MIN_INT:     min_int_r  <= cfg_data[31:0];
        REG_STALE:       stale_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] vc_r, vc_nxt;
  logic [31:0]   wstart_r, wstart_nxt;
  logic [8:0]    wcnt_r, wcnt_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [7:0]    bhops_r, bhops_nxt;
  logic [31:0]   btime_r, btime_nxt;
  logic          vic_vld_r, vic_vld_nxt;
  logic [IW-1:0] vic_r, vic_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [1:0]        kind_r;
  logic [63:0]       dh_r, dl_r, ih_r, il_r;
  logic [31:0]       now_r;
  logic [7:0]        hops_r;
  logic signed [9:0] rssi_r, snr_r;
  logic [3:0]        st_r, st_nxt;
  logic [IW-1:0]     slot_r, slot_nxt;
  entry_t            ent_r, ent_nxt;
  logic [3:0]        out_status_r;
  logic [4:0]        out_slot_r;
  logic [5:0]        out_count_r;

  // Memory port.
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, q;

  ant_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (q)
  );

  logic          accept;
  logic          issuing;
  logic          is_last;
  logic [CW-1:0] last_idx;
  logic          match, stale, worse, interval_hit;
  logic [31:0]   elapsed, age;
  logic [CW-1:0] kept;
  logic [31:0]   win_start_c;
  logic [8:0]    win_cnt_c;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign last_idx = vc_r - 1'b1;
  assign issuing  = (issue_r < vc_r);
  assign is_last  = pv_r && (CW'(pidx_r) == last_idx);
  assign mem_raddr = (state_r == S_MVRD) ? last_idx[IW-1:0] : issue_r[IW-1:0];

  assign match = (q.dest_high == dh_r) && (q.dest_low == dl_r);
  assign age   = now_r - q.last_seen;
  assign stale = !q.saved && ((q.last_seen == '0) || (now_r < q.last_seen) || (age > stale_r));
  assign worse = !q.saved && ((q.hops > bhops_r) ||
                              ((q.hops == bhops_r) && (q.last_seen < btime_r)));
  assign elapsed = now_r - ent_r.last_seen;
  assign interval_hit = (ent_r.last_seen != '0) && (now_r >= ent_r.last_seen) &&
                        (elapsed < min_int_r);
  assign kept = w_r + CW'(!stale);

  // Rate window as seen by the incoming announce.
  always_comb begin
    win_start_c = wstart_r;
    win_cnt_c   = wcnt_r;
    if ((in_ch.now_ms - wstart_r) >= WINDOW_MS) begin
      win_start_c = in_ch.now_ms;
      win_cnt_c   = '0;
    end
    if (win_cnt_c < WINDOW_COUNT_MAX) begin
      win_cnt_c = win_cnt_c + 9'd1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    vc_nxt      = vc_r;
    wstart_nxt  = wstart_r;
    wcnt_nxt    = wcnt_r;
    issue_nxt   = issue_r;
    pidx_nxt    = issue_r[IW-1:0];
    w_nxt       = w_r;
    bhops_nxt   = bhops_r;
    btime_nxt   = btime_r;
    vic_vld_nxt = vic_vld_r;
    vic_nxt     = vic_r;
    st_nxt      = st_r;
    slot_nxt    = slot_r;
    ent_nxt     = ent_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_we      = 1'b0;
    mem_waddr   = slot_r;
    mem_wdata   = ent_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          issue_nxt = '0;
          slot_nxt  = '0;
          if (in_ch.kind == KIND_ANNOUNCE) begin
            if (lh_valid_r && (in_ch.dest_high == lh_high_r) &&
                (in_ch.dest_low == lh_low_r)) begin
              st_nxt    = ST_OWN;
              state_nxt = S_DONE;
            end else begin
              wstart_nxt = win_start_c;
              wcnt_nxt   = win_cnt_c;
              if (win_cnt_c > {1'b0, aps_r}) begin
                st_nxt    = ST_RATE;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
          end else if ((in_ch.kind == KIND_SAVE) || (in_ch.kind == KIND_UNSAVE)) begin
            state_nxt = S_SRCH;
          end else begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end
      end
      S_SRCH: begin
        if (issuing) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (pv_r && match) begin
          ent_nxt   = q;
          slot_nxt  = pidx_r;
          state_nxt = S_FOUND;
        end else if ((vc_r == '0) || is_last) begin
          issue_nxt = '0;
          w_nxt     = '0;
          if (kind_r != KIND_ANNOUNCE) begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else if (vc_r >= FULL_COUNT) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_INS;
          end
        end
      end
      S_FOUND: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
        if (kind_r == KIND_ANNOUNCE) begin
          if (interval_hit) begin
            mem_we = 1'b0;
            st_nxt = ST_INTERVAL;
          end else begin
            mem_wdata.ident_high = ih_r;
            mem_wdata.ident_low  = il_r;
            mem_wdata.last_seen  = now_r;
            mem_wdata.hops       = hops_r;
            if (rssi_r != '0) mem_wdata.rssi = rssi_r;
            if (snr_r != '0) mem_wdata.snr = snr_r;
            st_nxt = ST_UPDATED;
          end
        end else begin
          mem_wdata.saved = (kind_r == KIND_SAVE);
          st_nxt = (kind_r == KIND_SAVE) ? ST_SAVED : ST_UNSAVED;
        end
      end
      S_CMP: begin
        if (issuing) begin
          issue_nxt = issue_r + 1'b1;
        end
        mem_waddr = w_r[IW-1:0];
        mem_wdata = q;
        if (pv_r) begin
          mem_we = !stale;
          w_nxt  = kept;
          if (is_last) begin
            vc_nxt      = kept;
            issue_nxt   = '0;
            bhops_nxt   = '0;
            btime_nxt   = '1;
            vic_vld_nxt = 1'b0;
            state_nxt   = (kept >= FULL_COUNT) ? S_WRST : S_INS;
          end
        end
      end
      S_WRST: begin
        if (issuing) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (pv_r && worse) begin
          bhops_nxt   = q.hops;
          btime_nxt   = q.last_seen;
          vic_vld_nxt = 1'b1;
          vic_nxt     = pidx_r;
        end
        if (is_last) begin
          if (vic_vld_nxt) begin
            state_nxt = S_MVRD;
          end else begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end
        end
      end
      S_MVRD: begin
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        mem_we    = 1'b1;
        mem_waddr = vic_r;
        mem_wdata = q;
        vc_nxt    = last_idx;
        state_nxt = S_INS;
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = vc_r[IW-1:0];
        mem_wdata = '{dest_high: dh_r, dest_low: dl_r, ident_high: ih_r, ident_low: il_r,
                      last_seen: now_r, hops: hops_r, rssi: rssi_r, snr: snr_r,
                      saved: 1'b0};
        slot_nxt  = vc_r[IW-1:0];
        vc_nxt    = vc_r + 1'b1;
        st_nxt    = ST_INSERTED;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A read is only tracked while the scan stays in the same state.
    pv_nxt = issuing && (state_nxt == state_r) &&
             ((state_r == S_SRCH) || (state_r == S_CMP) || (state_r == S_WRST));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= '0;
      wstart_r    <= '0;
      wcnt_r      <= '0;
      issue_r     <= '0;
      pv_r        <= 1'b0;
      w_r         <= '0;
      vic_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      wstart_r    <= wstart_nxt;
      wcnt_r      <= wcnt_nxt;
      issue_r     <= issue_nxt;
      pv_r        <= pv_nxt;
      w_r         <= w_nxt;
      vic_vld_r   <= vic_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    bhops_r <= bhops_nxt;
    btime_r <= btime_nxt;
    vic_r   <= vic_nxt;
    st_r    <= st_nxt;
    slot_r  <= slot_nxt;
    ent_r   <= ent_nxt;
    if (accept) begin
      kind_r <= in_ch.kind;
      dh_r   <= in_ch.dest_high;
      dl_r   <= in_ch.dest_low;
      ih_r   <= in_ch.ident_high;
      il_r   <= in_ch.ident_low;
      now_r  <= in_ch.now_ms;
      hops_r <= in_ch.hop_count;
      rssi_r <= in_ch.rssi_dbm;
      snr_r  <= in_ch.snr_quarter_db;
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= st_r;
      out_slot_r   <= 5'(slot_r);
      out_count_r  <= 6'(vc_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.entry_count = out_count_r;

  `include "announce_neighbor_table_assert.svh"

  `ANT_ASSERT(a_count_bound, (vc_r <= FULL_COUNT), "valid count beyond table depth")
  `ANT_ASSERT_IMP(a_grow_by_one, 1'b1, (vc_r <= $past(vc_r) + 1'b1) || $past(!rst_n),
                  "valid count grew by more than one")
  `ANT_ASSERT_IMP(a_no_scan_on_accept, accept, !pv_r, "transaction taken during a scan")
endmodule
